// ===== hdl/cfr_pkg.sv =====
package cfr_pkg;

    // opcodes of an input transaction
    localparam logic [1:0] OP_CHUNK = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_NEED_MORE = 2'd0;
    localparam logic [1:0] ST_READY     = 2'd1;
    localparam logic [1:0] ST_ERROR     = 2'd2;
    localparam logic [1:0] ST_READ      = 2'd3;

    // header layout and frame limits
    localparam int MORE_BIT     = 7;
    localparam int MIN_FRAME    = 4;
    localparam int LEN_OVERHEAD = 2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic       chunk_end;
        logic [9:0] read_index;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] frame_length;
        logic [7:0]  read_data;
    } out_t;

    // result of one accepted transaction, before the store read data joins it
    typedef struct packed {
        logic        valid;
        logic        is_read;
        logic        in_range;
        logic [1:0]  status;
        logic [10:0] frame_length;
    } res_t;

endpackage

// ===== hdl/cfr_ram.sv =====
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cfr_ctrl.sv =====
module cfr_ctrl #(
    parameter int BUF_DEPTH = 1024,
    parameter int SEQ_BITS  = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  cfr_pkg::in_t                 req,
    output logic                         wr_en,
    output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
    output logic [7:0]                   wr_data,
    output logic                         rd_en,
    output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
    output cfr_pkg::res_t                res
);

    localparam int ADDR_W  = $clog2(BUF_DEPTH);
    localparam int LEN_W   = $clog2(BUF_DEPTH + 1);
    localparam int CNT_CAP = BUF_DEPTH + 2;
    localparam int CNT_W   = $clog2(BUF_DEPTH + 3);
    localparam int SUM_W   = $clog2(2 * BUF_DEPTH + 3);
    localparam int CMP_W   = (SUM_W > 17) ? SUM_W : 17;

    logic [LEN_W-1:0]    stored_len_reg, stored_len_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SEQ_BITS-1:0] exp_seq_reg, exp_seq_next;
    logic                done_reg, done_next;
    logic                more_reg, more_next;
    logic                match_reg, match_next;
    logic [7:0]          len_hi_reg, len_hi_next;
    logic [7:0]          len_lo_reg, len_lo_next;

    logic                is_header;
    logic [LEN_W-1:0]    base_len;
    logic [SEQ_BITS-1:0] base_seq;
    logic [SUM_W-1:0]    pos;
    logic                pos_ok;
    logic [7:0]          hi_eff;
    logic [7:0]          lo_eff;
    logic                more_eff;
    logic                match_eff;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    body;
    logic [SUM_W-1:0]    len;
    logic [CMP_W-1:0]    len_c;
    logic [CMP_W-1:0]    total;
    logic                err_basic;
    logic                err_decl;
    logic                chunk_err;
    logic                in_range;

    // chunk position and header fields as seen by this transaction
    always_comb
    begin
        is_header = (cnt_reg == '0);
        base_len  = (is_header && done_reg) ? '0 : stored_len_reg;
        base_seq  = (is_header && done_reg) ? '0 : exp_seq_reg;
        pos       = SUM_W'(stored_len_reg) + SUM_W'(cnt_reg) - SUM_W'(1);
        pos_ok    = !is_header && (pos < SUM_W'(BUF_DEPTH));
        hi_eff    = (pos_ok && pos == SUM_W'(0)) ? req.data_byte : len_hi_reg;
        lo_eff    = (pos_ok && pos == SUM_W'(1)) ? req.data_byte : len_lo_reg;
        more_eff  = is_header ? req.data_byte[cfr_pkg::MORE_BIT] : more_reg;
        match_eff = is_header ? (req.data_byte[SEQ_BITS-1:0] == base_seq) : match_reg;
        cnt_inc   = (cnt_reg < CNT_W'(CNT_CAP)) ? cnt_reg + CNT_W'(1) : cnt_reg;
        body      = cnt_inc - CNT_W'(1);
        len       = SUM_W'(base_len) + SUM_W'(body);
        len_c     = CMP_W'(len);
        total     = CMP_W'({hi_eff, lo_eff}) + CMP_W'(cfr_pkg::LEN_OVERHEAD);
    end

    // chunk-end checks
    always_comb
    begin
        err_basic = !match_eff || (body == '0) || (len > SUM_W'(BUF_DEPTH));
        err_decl  = (len_c >= CMP_W'(2)) &&
                    ((total < CMP_W'(cfr_pkg::MIN_FRAME)) ||
                     (total > CMP_W'(BUF_DEPTH)) ||
                     (len_c > total) ||
                     (!more_eff && len_c != total));
        chunk_err = err_basic || err_decl ||
                    (!more_eff && len_c < CMP_W'(cfr_pkg::MIN_FRAME));
        in_range  = (CMP_W'(req.read_index) < CMP_W'(stored_len_reg)) &&
                    (CMP_W'(req.read_index) < CMP_W'(BUF_DEPTH));
    end

    // per-opcode state update, store access and result
    always_comb
    begin
        stored_len_next = stored_len_reg;
        cnt_next        = cnt_reg;
        exp_seq_next    = exp_seq_reg;
        done_next       = done_reg;
        more_next       = more_reg;
        match_next      = match_reg;
        len_hi_next     = len_hi_reg;
        len_lo_next     = len_lo_reg;
        wr_en           = 1'b0;
        wr_addr         = ADDR_W'(pos);
        wr_data         = req.data_byte;
        rd_en           = 1'b0;
        rd_addr         = ADDR_W'(req.read_index);
        res             = '0;

        case (req.opcode)
            cfr_pkg::OP_READ:
            begin
                rd_en            = accept && in_range;
                res.valid        = accept;
                res.is_read      = 1'b1;
                res.in_range     = in_range;
                res.status       = cfr_pkg::ST_READ;
                res.frame_length = 11'(stored_len_reg);
            end
            cfr_pkg::OP_EMPTY:
            begin
                cnt_next         = '0;
                stored_len_next  = '0;
                exp_seq_next     = '0;
                done_next        = 1'b0;
                res.valid        = accept;
                res.status       = cfr_pkg::ST_ERROR;
                res.frame_length = '0;
            end
            cfr_pkg::OP_CHUNK:
            begin
                if (is_header)
                begin
                    more_next       = more_eff;
                    match_next      = match_eff;
                    stored_len_next = base_len;
                    exp_seq_next    = base_seq;
                    done_next       = 1'b0;
                end
                else
                begin
                    wr_en       = accept && pos_ok;
                    len_hi_next = hi_eff;
                    len_lo_next = lo_eff;
                end
                cnt_next = cnt_inc;
                if (req.chunk_end)
                begin
                    cnt_next  = '0;
                    res.valid = accept;
                    if (chunk_err)
                    begin
                        stored_len_next  = '0;
                        exp_seq_next     = '0;
                        done_next        = 1'b0;
                        res.status       = cfr_pkg::ST_ERROR;
                        res.frame_length = '0;
                    end
                    else
                    begin
                        stored_len_next  = LEN_W'(len);
                        exp_seq_next     = base_seq + SEQ_BITS'(1);
                        res.frame_length = 11'(len);
                        if (more_eff)
                        begin
                            res.status = cfr_pkg::ST_NEED_MORE;
                        end
                        else
                        begin
                            res.status = cfr_pkg::ST_READY;
                            done_next  = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    // reassembly state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_len_reg <= '0;
            cnt_reg        <= '0;
            exp_seq_reg    <= '0;
            done_reg       <= 1'b0;
            more_reg       <= 1'b0;
            match_reg      <= 1'b0;
            len_hi_reg     <= '0;
            len_lo_reg     <= '0;
        end
        else if (accept)
        begin
            stored_len_reg <= stored_len_next;
            cnt_reg        <= cnt_next;
            exp_seq_reg    <= exp_seq_next;
            done_reg       <= done_next;
            more_reg       <= more_next;
            match_reg      <= match_next;
            len_hi_reg     <= len_hi_next;
            len_lo_reg     <= len_lo_next;
        end
    end

endmodule

// ===== hdl/chunk_frame_reassembler_unit.sv =====
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | cfr_pkg::in_t  (opcode, data_byte, chunk_end, read_index)
// rsp     | out | rsp_valid/rsp_ready  | cfr_pkg::out_t (status, frame_length, read_data)
//
// one transaction per cycle sustained while rsp is not stalled; a result is registered in the
// frame store read stage, then in the output register
// frame store is a one-write one-read ram; a byte write and a read never conflict
// since a write lands at the accept edge, before any later read is issued
// reset clears all reassembly state at once; the frame store is not cleared
// a stalled rsp holds two results (read stage and output register) before req_ready drops
module chunk_frame_reassembler_unit #(
    parameter int BUF_DEPTH = 1024,
    parameter int SEQ_BITS  = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cfr_pkg::in_t  req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cfr_pkg::out_t rsp
);

    localparam int ADDR_W = $clog2(BUF_DEPTH);

    logic                req_accept;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [7:0]          rd_data;
    cfr_pkg::res_t       res;

    logic                s1_valid_reg, s1_valid_next;
    cfr_pkg::res_t       s1_res_reg, s1_res_next;
    logic                rsp_valid_reg, rsp_valid_next;
    cfr_pkg::out_t       rsp_reg, rsp_next;
    logic                out_load;

    // reassembly control and chunk checks
    cfr_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .SEQ_BITS  (SEQ_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (req_accept),
        .req     (req),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .res     (res)
    );

    // frame store
    cfr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // handshake: the read stage moves whenever the output register can take it
    always_comb
    begin
        out_load   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
        req_ready  = !s1_valid_reg || !rsp_valid_reg || rsp_ready;
        req_accept = req_valid && req_ready;
    end

    // read stage and output register next values
    always_comb
    begin
        s1_res_next   = req_accept ? res : s1_res_reg;
        s1_valid_next = req_accept ? res.valid : (out_load ? 1'b0 : s1_valid_reg);

        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_ready ? 1'b0 : rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.status       = s1_res_reg.status;
            rsp_next.frame_length = s1_res_reg.frame_length;
            rsp_next.read_data    = (s1_res_reg.is_read && s1_res_reg.in_range) ? rd_data : '0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_res_reg <= s1_res_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // an error always leaves an empty frame
    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == cfr_pkg::ST_ERROR |-> rsp.frame_length == '0)
        else $error("error result with nonzero frame length");

    // only read results carry store data
    a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != cfr_pkg::ST_READ |-> rsp.read_data == '0)
        else $error("read data on a non-read result");

    // a ready frame meets the minimum length
    a_ready_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == cfr_pkg::ST_READY |->
            (rsp.frame_length >= 11'(cfr_pkg::MIN_FRAME)) || (BUF_DEPTH > 2047))
        else $error("frame ready below minimum length");

    // both stages full and stalled: no new request may enter
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && rsp_valid_reg && !rsp_ready |-> !req_ready)
        else $error("request accepted while pipeline full");

endmodule
